### sv/sfcr_pkg.sv
// Shared package for the scaled font character renderer.
// Holds the font table, register indexes, reset values and the control structs.
// No dependencies.
`default_nettype none

package sfcr_pkg;

    localparam int FONT_SCALE_DEF        = 2;
    localparam int PIXELS_PER_RESULT_DEF = 4;

    localparam int GLYPH_W    = 5;
    localparam int GLYPH_H    = 7;
    localparam int CELL_W_DIV = 6;
    localparam int CELL_H_DIV = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_TEXT_COLUMNS = 3'd0;
    localparam t_cfg_idx CFG_TEXT_ROWS    = 3'd1;
    localparam t_cfg_idx CFG_X_OFFSET     = 3'd2;
    localparam t_cfg_idx CFG_Y_OFFSET     = 3'd3;

    localparam logic [4:0] TEXT_COLUMNS_RST = 5'd20;
    localparam logic [4:0] TEXT_ROWS_RST    = 5'd17;
    localparam logic [6:0] X_OFFSET_RST     = 7'd0;
    localparam logic [6:0] Y_OFFSET_RST     = 7'd20;

    localparam logic [7:0] CHAR_FIRST = 8'h20;
    localparam logic [7:0] CHAR_LAST  = 8'h7E;

    localparam int FONT_DEPTH = 96;
    localparam int FONT_IDX_W = $clog2(FONT_DEPTH);

    // One entry per glyph, column 0 in the top byte. Bit 0 of a byte is the top row.
    localparam logic [39:0] FONT_ROM [FONT_DEPTH] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001C224100, 40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
        40'h0008142241, 40'h1414141414, 40'h4122140800, 40'h0201510906,
        40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
        40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h00007F4141,
        40'h0204081020, 40'h41417F0000, 40'h0402010204, 40'h4040404040,
        40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
        40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
        40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
        40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
        40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
        40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
        40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
        40'h00007F0000, 40'h0041360800, 40'h0804081008, 40'hFFFFFFFFFF
    };

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // latch a new character and clear the cell counters
        logic advance;  // register the current pixel group and step the counters
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_range;    // the offered character lies inside the text grid
        logic last_group;  // the counters point at the final group of the cell
    } t_stat;

endpackage

`default_nettype wire

### sv/sfcr_char_if.sv
// Character request channel of the scaled font character renderer.
// Depends on nothing.
`default_nettype none

interface sfcr_char_if;
    logic        valid;
    logic        ready;
    logic [7:0]  char_row;
    logic [7:0]  char_col;
    logic [7:0]  char_code;
    logic [15:0] fore_colour;
    logic [15:0] back_colour;

    modport source (
        output valid, char_row, char_col, char_code, fore_colour, back_colour,
        input  ready
    );
    modport sink (
        input  valid, char_row, char_col, char_code, fore_colour, back_colour,
        output ready
    );
endinterface

`default_nettype wire

### sv/sfcr_pix_if.sv
// Pixel group request channel of the scaled font character renderer.
// Depends on nothing.
`default_nettype none

interface sfcr_pix_if;
    logic        valid;
    logic        ready;
    logic [8:0]  screen_x;
    logic [8:0]  screen_y;
    logic [15:0] pixel_first;
    logic [15:0] pixel_second;
    logic [15:0] pixel_third;
    logic [15:0] pixel_fourth;
    logic        last_of_char;

    modport source (
        output valid, screen_x, screen_y, pixel_first, pixel_second, pixel_third,
               pixel_fourth, last_of_char,
        input  ready
    );
    modport sink (
        input  valid, screen_x, screen_y, pixel_first, pixel_second, pixel_third,
               pixel_fourth, last_of_char,
        output ready
    );
endinterface

`default_nettype wire

### sv/scaled_font_character_renderer_unit.sv
// Scaled font character renderer top level; uses sfcr_pkg, sfcr_char_if, sfcr_pix_if,
// sfcr_ctrl and sfcr_datapath.
// An accepted character is latched into the datapath registers; its groups then pass through
// the output register: 8*FONT_SCALE lines of ceil(6*FONT_SCALE/PIXELS_PER_RESULT) groups,
// one per cycle unless the output stalls, so 48 groups per character at the defaults; a
// character outside the grid is accepted but gives no groups. Reset (synchronous, active low)
// idles the controller and restores 20 columns, 17 rows, x offset 0 and y offset 20.
`default_nettype none

module scaled_font_character_renderer_unit #(
    parameter int FONT_SCALE        = sfcr_pkg::FONT_SCALE_DEF,
    parameter int PIXELS_PER_RESULT = sfcr_pkg::PIXELS_PER_RESULT_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire sfcr_pkg::t_cfg_idx              i_cfg_idx,
    input  wire logic [sfcr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    sfcr_char_if.sink                            i_char,
    sfcr_pix_if.source                           o_pix
);
    import sfcr_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // The controller decides when a character request is taken and when the
    // output register moves on; it never looks at the payload itself. The next
    // character is accepted in the cycle the last group of the current one is
    // loaded into the output register.
    sfcr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_char.valid),
        .o_in_ready  (i_char.ready),
        .o_out_valid (o_pix.valid),
        .i_out_ready (o_pix.ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // The datapath holds the configuration, the latched glyph and colours, the
    // line and group counters and the registered pixel group request.
    sfcr_datapath #(
        .FONT_SCALE        (FONT_SCALE),
        .PIXELS_PER_RESULT (PIXELS_PER_RESULT)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_char_row     (i_char.char_row),
        .i_char_col     (i_char.char_col),
        .i_char_code    (i_char.char_code),
        .i_fore_colour  (i_char.fore_colour),
        .i_back_colour  (i_char.back_colour),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_screen_x     (o_pix.screen_x),
        .o_screen_y     (o_pix.screen_y),
        .o_pixel_first  (o_pix.pixel_first),
        .o_pixel_second (o_pix.pixel_second),
        .o_pixel_third  (o_pix.pixel_third),
        .o_pixel_fourth (o_pix.pixel_fourth),
        .o_last_of_char (o_pix.last_of_char)
    );

endmodule

`default_nettype wire

### sv/sfcr_ctrl.sv
// Controller of the scaled font character renderer: accepts characters and
// paces the pixel group output register. Depends on sfcr_pkg.
`default_nettype none

module sfcr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output sfcr_pkg::t_cmd     o_cmd,
    input  wire sfcr_pkg::t_stat i_stat
);
    import sfcr_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   adv, accept, finish;

    assign adv        = (r_state == ST_RUN) && (!r_out_valid || i_out_ready);
    assign finish     = adv && i_stat.last_group;
    assign o_in_ready = (r_state == ST_IDLE) || finish;
    assign accept     = i_in_valid && o_in_ready;

    assign o_cmd.load    = accept && i_stat.in_range;
    assign o_cmd.advance = adv;
    assign o_out_valid   = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (adv) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (accept && i_stat.in_range) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (finish) begin
                    n_state = (accept && i_stat.in_range) ? ST_RUN : ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

### sv/sfcr_datapath.sv
// Datapath of the scaled font character renderer: configuration registers,
// character latches, cell counters, pixel expansion and the output register.
// Depends on sfcr_pkg.
`default_nettype none

module sfcr_datapath #(
    parameter int FONT_SCALE        = sfcr_pkg::FONT_SCALE_DEF,
    parameter int PIXELS_PER_RESULT = sfcr_pkg::PIXELS_PER_RESULT_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire sfcr_pkg::t_cfg_idx         i_cfg_idx,
    input  wire logic [sfcr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [7:0]                 i_char_row,
    input  wire logic [7:0]                 i_char_col,
    input  wire logic [7:0]                 i_char_code,
    input  wire logic [15:0]                i_fore_colour,
    input  wire logic [15:0]                i_back_colour,
    input  wire sfcr_pkg::t_cmd             i_cmd,
    output sfcr_pkg::t_stat                 o_stat,
    output logic [8:0]                      o_screen_x,
    output logic [8:0]                      o_screen_y,
    output logic [15:0]                     o_pixel_first,
    output logic [15:0]                     o_pixel_second,
    output logic [15:0]                     o_pixel_third,
    output logic [15:0]                     o_pixel_fourth,
    output logic                            o_last_of_char
);
    import sfcr_pkg::*;

    localparam int CELL_W   = CELL_W_DIV * FONT_SCALE;
    localparam int CELL_H   = CELL_H_DIV * FONT_SCALE;
    localparam int GROUPS   = (CELL_W + PIXELS_PER_RESULT - 1) / PIXELS_PER_RESULT;
    localparam int LINE_W   = $clog2(CELL_H);
    localparam int GRP_W    = $clog2(GROUPS);
    localparam int X_W      = $clog2(CELL_W + 4);
    localparam int PRODX_W  = 5 + $clog2(CELL_W + 1);
    localparam int PRODY_W  = 5 + $clog2(CELL_H + 1);

    localparam logic [LINE_W-1:0] LINE_LAST = LINE_W'(CELL_H - 1);
    localparam logic [GRP_W-1:0]  GRP_LAST  = GRP_W'(GROUPS - 1);

    // Configuration registers.
    logic [4:0] r_text_columns, r_text_rows;
    logic [6:0] r_x_offset, r_y_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_columns <= TEXT_COLUMNS_RST;
            r_text_rows    <= TEXT_ROWS_RST;
            r_x_offset     <= X_OFFSET_RST;
            r_y_offset     <= Y_OFFSET_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TEXT_COLUMNS: r_text_columns <= i_cfg_data[4:0];
                CFG_TEXT_ROWS:    r_text_rows    <= i_cfg_data[4:0];
                CFG_X_OFFSET:     r_x_offset     <= i_cfg_data;
                CFG_Y_OFFSET:     r_y_offset     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_stat.in_range = (i_char_row < {3'b000, r_text_rows}) &&
                             (i_char_col < {3'b000, r_text_columns});

    // Glyph lookup and cell origin for the offered character.
    logic [7:0]            code_fix;
    logic [FONT_IDX_W-1:0] font_idx;
    logic [39:0]           font_word;
    logic [4:0][6:0]       glyph_in;
    logic [PRODX_W-1:0]    prod_x;
    logic [PRODY_W-1:0]    prod_y;
    logic [8:0]            base_x_in, base_y_in;

    always_comb begin
        code_fix = ((i_char_code < CHAR_FIRST) || (i_char_code > CHAR_LAST)) ?
                   CHAR_FIRST : i_char_code;
        font_idx  = FONT_IDX_W'(code_fix - CHAR_FIRST);
        font_word = FONT_ROM[font_idx];
        for (int k = 0; k < GLYPH_W; k++) begin
            glyph_in[k] = font_word[39 - 8 * k - 1 -: 7];
        end
        // An accepted column is below the 5-bit column count.
        prod_x    = PRODX_W'(i_char_col[4:0]) * PRODX_W'(CELL_W);
        prod_y    = PRODY_W'(i_char_row[4:0]) * PRODY_W'(CELL_H);
        base_x_in = 9'(prod_x) + {2'b00, r_x_offset};
        base_y_in = 9'(prod_y) + {2'b00, r_y_offset};
    end

    logic [4:0][6:0]   r_glyph;
    logic [15:0]       r_fore, r_back;
    logic [8:0]        r_base_x, r_base_y;
    logic [LINE_W-1:0] r_line;
    logic [GRP_W-1:0]  r_group;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_glyph  <= glyph_in;
            r_fore   <= i_fore_colour;
            r_back   <= i_back_colour;
            r_base_x <= base_x_in;
            r_base_y <= base_y_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line  <= '0;
            r_group <= '0;
        end else if (i_cmd.load) begin
            r_line  <= '0;
            r_group <= '0;
        end else if (i_cmd.advance) begin
            if (r_group == GRP_LAST) begin
                r_group <= '0;
                r_line  <= r_line + 1'b1;
            end else begin
                r_group <= r_group + 1'b1;
            end
        end
    end

    assign o_stat.last_group = (r_line == LINE_LAST) && (r_group == GRP_LAST);

    // Pixel expansion for the current group. Glyph row and column come from
    // comparing against multiples of the scale factor.
    logic [X_W-1:0]   x0;
    logic [X_W-1:0]   px [4];
    logic [2:0]       gc [4];
    logic [2:0]       gr;
    logic             row_lit;
    logic [3:0][15:0] pix;

    always_comb begin
        x0 = X_W'(r_group) * X_W'(PIXELS_PER_RESULT);
        gr = '0;
        for (int k = 1; k < GLYPH_H; k++) begin
            if (r_line >= LINE_W'(k * FONT_SCALE)) begin
                gr = gr + 3'd1;
            end
        end
        row_lit = (r_line < LINE_W'(GLYPH_H * FONT_SCALE));
        for (int p = 0; p < 4; p++) begin
            px[p] = x0 + X_W'(p);
            gc[p] = '0;
            for (int k = 1; k < GLYPH_W; k++) begin
                if (px[p] >= X_W'(k * FONT_SCALE)) begin
                    gc[p] = gc[p] + 3'd1;
                end
            end
            if ((p >= PIXELS_PER_RESULT) || (px[p] >= X_W'(CELL_W))) begin
                pix[p] = '0;
            end else if (row_lit && (px[p] < X_W'(GLYPH_W * FONT_SCALE)) &&
                         r_glyph[gc[p]][gr]) begin
                pix[p] = r_fore;
            end else begin
                pix[p] = r_back;
            end
        end
    end

    // Output register, loaded once per group.
    always_ff @(posedge i_clk) begin
        if (i_cmd.advance) begin
            o_screen_x     <= r_base_x + 9'(x0);
            o_screen_y     <= r_base_y + 9'(r_line);
            o_pixel_first  <= pix[0];
            o_pixel_second <= pix[1];
            o_pixel_third  <= pix[2];
            o_pixel_fourth <= pix[3];
            o_last_of_char <= o_stat.last_group;
        end
    end

endmodule

`default_nettype wire
